FILE: hdl/sacvb_pkg.sv
// ----------------------------------------------------------------------------
// sacvb_pkg
// Shared types and constants of the set-associative cache tag directory.
// ----------------------------------------------------------------------------
package sacvb_pkg;

  localparam int unsigned SetsDef      = 64;
  localparam int unsigned WaysDef      = 8;
  localparam int unsigned LineBytesDef = 64;
  localparam int unsigned VictimDef    = 8;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned OutcomeW = 2;
  localparam int unsigned SetW     = 6;
  localparam int unsigned WayW     = 3;
  localparam int unsigned WbLineW  = 26;
  localparam int unsigned AgeW     = 8;
  localparam logic [AgeW-1:0] AgeMax = 8'd255;

  localparam logic [OutcomeW-1:0] OUT_MISS   = 2'd0;
  localparam logic [OutcomeW-1:0] OUT_HIT    = 2'd1;
  localparam logic [OutcomeW-1:0] OUT_VICTIM = 2'd2;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // result word, highest field first
  typedef struct packed {
    logic               victim_push;
    logic [WbLineW-1:0] writeback_line;
    logic               writeback_valid;
    logic [WayW-1:0]    hit_way;
    logic [SetW-1:0]    set_index;
    logic [OutcomeW-1:0] outcome;
  } result_t;

endpackage

FILE: hdl/set_assoc_cache_with_victim_buffer.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_with_victim_buffer
// Tag directory of a write-back set-associative cache with a victim buffer.
// ----------------------------------------------------------------------------
// Input channel s_axis_*: tuser carries the command (0 read, 1 write), tdata
// the 32-bit byte address. Output channel m_axis_*: one result word per
// access, packed into tdata.
// Each access passes the accept cycle, a read of the set's row from the tag
// and age memories, and a cycle that resolves hit, victim search and oldest
// way, writes the row back and registers the result. The next access is
// accepted only after that result is registered; one access is in flight
// at a time, so no forwarding is needed.
// After reset a clearing pass writes every set's row while the input is
// held not ready. The victim buffer lives in flip-flops with a count and a
// head pointer.
// A stalled receiver holds the result in the output register; one further
// access may be accepted and run up to that register, where it waits.
// ----------------------------------------------------------------------------
module set_assoc_cache_with_victim_buffer #(
  parameter int unsigned SETS           = sacvb_pkg::SetsDef,
  parameter int unsigned WAYS           = sacvb_pkg::WaysDef,
  parameter int unsigned LINE_BYTES     = sacvb_pkg::LineBytesDef,
  parameter int unsigned VICTIM_ENTRIES = sacvb_pkg::VictimDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] address
  input  logic        s_axis_tuser_i,   // [0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [1:0] outcome, [7:2] set_index,
                                        // [10:8] hit_way, [11] writeback_valid,
                                        // [37:12] writeback_line,
                                        // [38] victim_push
);
  import sacvb_pkg::*;

  localparam int unsigned OffW  = $clog2(LINE_BYTES);
  localparam int unsigned SIdxW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned SBits = $clog2(SETS);
  localparam int unsigned LineW = AddrW - OffW;
  localparam int unsigned TagW  = LineW - SBits;
  localparam int unsigned WIdxW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned VIdxW = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
  localparam int unsigned VCntW = $clog2(VICTIM_ENTRIES + 1);
  localparam int unsigned EntW  = TagW + 2;   // {valid, dirty, tag}
  localparam logic [VCntW-1:0] VFull = VCntW'(VICTIM_ENTRIES);

  typedef logic [WAYS-1:0][EntW-1:0] tag_row_t;
  typedef logic [WAYS-1:0][AgeW-1:0] age_row_t;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_EVAL = 2'd3;

  logic [1:0] state_q, state_d;
  logic [SIdxW-1:0] clr_q;
  logic [AddrW-1:0] addr_q;
  logic             cmd_q;

  tag_row_t tag_mem [SETS];
  age_row_t age_mem [SETS];
  tag_row_t tag_rd_q;
  age_row_t age_rd_q;

  logic [VICTIM_ENTRIES-1:0][LineW-1:0] vl_q;
  logic [VCntW-1:0] vcnt_q;
  logic [VIdxW-1:0] vhead_q;

  logic    out_valid_q;
  result_t out_q;

  logic [LineW-1:0] line;
  logic [SIdxW-1:0] set_idx;
  logic [TagW-1:0]  tag;
  assign line    = addr_q[AddrW-1:OffW];
  assign set_idx = (SETS > 1) ? SIdxW'(line) : '0;
  assign tag     = TagW'(line >> SBits);

  // hit search, lowest way first
  logic             hit;
  logic [WIdxW-1:0] hit_w;
  always_comb begin
    hit   = 1'b0;
    hit_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (tag_rd_q[w][EntW-1] && tag_rd_q[w][TagW-1:0] == tag) begin
        hit   = 1'b1;
        hit_w = WIdxW'(w);
      end
    end
  end

  // oldest way, lowest wins ties
  logic [WIdxW-1:0] old_w;
  logic [AgeW-1:0]  old_a;
  always_comb begin
    old_w = '0;
    old_a = age_rd_q[0];
    for (int w = 1; w < WAYS; w++) begin
      if (age_rd_q[w] > old_a) begin
        old_a = age_rd_q[w];
        old_w = WIdxW'(w);
      end
    end
  end

  // victim search in FIFO order, oldest match first
  logic             vhit;
  logic [VCntW-1:0] vpos;
  always_comb begin
    vhit = 1'b0;
    vpos = '0;
    for (int i = VICTIM_ENTRIES - 1; i >= 0; i--) begin
      if (VCntW'(i) < vcnt_q &&
          vl_q[VIdxW'((VCntW+1)'(vhead_q) + (VCntW+1)'(i))] == line) begin
        vhit = 1'b1;
        vpos = VCntW'(i);
      end
    end
  end

  logic [WIdxW-1:0] use_w;
  logic [EntW-1:0]  ev_ent;
  logic [LineW-1:0] ev_line;
  tag_row_t         tag_new;
  age_row_t         age_new;
  result_t          res;
  assign use_w   = hit ? hit_w : old_w;
  assign ev_ent  = tag_rd_q[old_w];
  assign ev_line = LineW'({ev_ent[TagW-1:0], set_idx} >> (SIdxW - SBits));

  always_comb begin
    tag_new = tag_rd_q;
    if (hit) begin
      if (cmd_q == CMD_WRITE) tag_new[hit_w][EntW-2] = 1'b1;
    end else begin
      tag_new[old_w] = {1'b1, cmd_q == CMD_WRITE, tag};
    end
    for (int w = 0; w < WAYS; w++) begin
      if (WIdxW'(w) == use_w) age_new[w] = '0;
      else if (age_rd_q[w] < AgeMax) age_new[w] = age_rd_q[w] + 1'b1;
      else age_new[w] = age_rd_q[w];
    end
    res = '0;
    res.set_index = SetW'(set_idx);
    res.hit_way   = WayW'(use_w);
    res.outcome   = hit ? OUT_HIT : (vhit ? OUT_VICTIM : OUT_MISS);
    if (!hit && ev_ent[EntW-1]) begin
      res.victim_push = 1'b1;
      if (ev_ent[EntW-2]) begin
        res.writeback_valid = 1'b1;
        res.writeback_line  = WbLineW'(ev_line);
      end
    end
  end

  logic out_free, in_acc, eval_go;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = state_q == ST_IDLE;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign eval_go         = state_q == ST_EVAL && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (clr_q == SIdxW'(SETS - 1)) state_d = ST_IDLE;
      ST_IDLE: if (in_acc) state_d = ST_RD;
      ST_RD:   state_d = ST_EVAL;
      ST_EVAL: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // row memories: one read and at most one write per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLR) begin
      tag_mem[clr_q] <= '0;
      age_mem[clr_q] <= '0;
    end else if (eval_go) begin
      tag_mem[set_idx] <= tag_new;
      age_mem[set_idx] <= age_new;
    end
    tag_rd_q <= tag_mem[set_idx];
    age_rd_q <= age_mem[set_idx];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q <= s_axis_tdata_i;
      cmd_q  <= s_axis_tuser_i;
    end
    if (eval_go) out_q <= res;
  end

  // victim buffer update: remove matched entry, then push evictee
  logic [VICTIM_ENTRIES-1:0][LineW-1:0] vl_d;
  logic [VCntW-1:0] vcnt_d;
  logic [VIdxW-1:0] vhead_d;
  always_comb begin
    vl_d    = vl_q;
    vcnt_d  = vcnt_q;
    vhead_d = vhead_q;
    if (!hit) begin
      if (vhit) begin
        for (int i = 0; i < VICTIM_ENTRIES - 1; i++) begin
          if (VCntW'(i) >= vpos && VCntW'(i + 1) < vcnt_q)
            vl_d[VIdxW'((VCntW+1)'(vhead_q) + (VCntW+1)'(i))] =
              vl_q[VIdxW'((VCntW+1)'(vhead_q) + (VCntW+1)'(i + 1))];
        end
        vcnt_d = vcnt_q - 1'b1;
      end
      if (ev_ent[EntW-1]) begin
        if (vcnt_d == VFull) begin
          vhead_d = (VICTIM_ENTRIES > 1) ?
                    VIdxW'(((VCntW+1)'(vhead_q) + 1'b1) % VICTIM_ENTRIES) : '0;
          vcnt_d  = VFull - 1'b1;
        end
        vl_d[VIdxW'(((VCntW+1)'(vhead_d) + (VCntW+1)'(vcnt_d)) % VICTIM_ENTRIES)] =
          ev_line;
        vcnt_d = vcnt_d + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_go) vl_q <= vl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      vcnt_q      <= '0;
      vhead_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) clr_q <= clr_q + 1'b1;
      if (eval_go) begin
        vcnt_q  <= vcnt_d;
        vhead_q <= vhead_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q};

  a_vcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= VFull) else $error("victim count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_RD) else $error("accept did not start a read");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_q))
    else $error("result lost under stall");
  a_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.outcome != 2'd3) else $error("bad outcome");
endmodule

FILE: test/sacvb_checker.sv
// ----------------------------------------------------------------------------
// sacvb_checker
// Watches both channels of the cache tag directory, predicts each result
// word from the accepted access and compares it field by field.
// ----------------------------------------------------------------------------
module sacvb_checker
  import sacvb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [31:0] s_addr_i,
  input  logic        s_cmd_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [39:0] m_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int Sets = 64;
  localparam int Ways = 8;
  localparam int Vict = 8;

  logic                dir_valid [Sets][Ways];
  logic                dir_dirty [Sets][Ways];
  logic [19:0]         dir_tag   [Sets][Ways];
  logic [AgeW-1:0]     dir_age   [Sets][Ways];
  logic [WbLineW-1:0]  vbuf      [Vict];
  int                  vcount;
  int                  vhead;
  result_t             expected_words [$];

  assign pending_o = expected_words.size();

  function automatic void age_set(int s, int used);
    for (int w = 0; w < Ways; w++) begin
      if (w == used) dir_age[s][w] = '0;
      else if (dir_age[s][w] != AgeMax) dir_age[s][w] = dir_age[s][w] + 1'b1;
    end
  endfunction

  function automatic result_t lookup_access(logic cmd, logic [31:0] addr);
    result_t r;
    logic [25:0] line;
    int s, way, best;
    bit hit;
    logic [25:0] ev;
    line = addr[31:6];
    s = line[5:0];
    hit = 0;
    way = 0;
    r = '0;
    r.set_index = line[5:0];
    for (int w = 0; w < Ways; w++) begin
      if (!hit && dir_valid[s][w] && dir_tag[s][w] == line[25:6]) begin
        hit = 1;
        way = w;
      end
    end
    if (hit) begin
      r.outcome = OUT_HIT;
      if (cmd == CMD_WRITE) dir_dirty[s][way] = 1'b1;
    end else begin
      r.outcome = OUT_MISS;
      for (int i = 0; i < vcount; i++) begin
        if (r.outcome == OUT_MISS && vbuf[(vhead + i) % Vict] == line) begin
          // close the gap left by the matched entry
          for (int j = i; j + 1 < vcount; j++)
            vbuf[(vhead + j) % Vict] = vbuf[(vhead + j + 1) % Vict];
          vcount--;
          r.outcome = OUT_VICTIM;
        end
      end
      best = 0;
      for (int w = 1; w < Ways; w++)
        if (dir_age[s][w] > dir_age[s][best]) best = w;
      way = best;
      if (dir_valid[s][way]) begin
        ev = {dir_tag[s][way], line[5:0]};
        if (dir_dirty[s][way]) begin
          r.writeback_valid = 1'b1;
          r.writeback_line = ev;
        end
        if (vcount >= Vict) begin
          vhead = (vhead + 1) % Vict;
          vcount = Vict - 1;
        end
        vbuf[(vhead + vcount) % Vict] = ev;
        vcount++;
        r.victim_push = 1'b1;
      end
      dir_valid[s][way] = 1'b1;
      dir_dirty[s][way] = (cmd == CMD_WRITE);
      dir_tag[s][way] = line[25:6];
    end
    age_set(s, way);
    r.hit_way = way[2:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, exp_w;
    if (!rst_ni) begin
      for (int s = 0; s < Sets; s++)
        for (int w = 0; w < Ways; w++) begin
          dir_valid[s][w] = 1'b0;
          dir_dirty[s][w] = 1'b0;
          dir_tag[s][w] = '0;
          dir_age[s][w] = '0;
        end
      vcount = 0;
      vhead = 0;
      expected_words.delete();
      fail_count_o = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        got = result_t'(m_data_i);
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, m_data_i);
          fail_count_o++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got.outcome !== exp_w.outcome)
            $display("%0t: outcome exp %0d got %0d", $time, exp_w.outcome, got.outcome);
          if (got.set_index !== exp_w.set_index)
            $display("%0t: set_index exp %0d got %0d", $time, exp_w.set_index,
                     got.set_index);
          if (got.hit_way !== exp_w.hit_way)
            $display("%0t: hit_way exp %0d got %0d", $time, exp_w.hit_way, got.hit_way);
          if (got.writeback_valid !== exp_w.writeback_valid)
            $display("%0t: writeback_valid exp %0d got %0d", $time,
                     exp_w.writeback_valid, got.writeback_valid);
          if (got.writeback_line !== exp_w.writeback_line)
            $display("%0t: writeback_line exp %h got %h", $time,
                     exp_w.writeback_line, got.writeback_line);
          if (got.victim_push !== exp_w.victim_push)
            $display("%0t: victim_push exp %0d got %0d", $time,
                     exp_w.victim_push, got.victim_push);
          if (got !== exp_w) fail_count_o++;
        end
      end
      if (s_valid_i && s_ready_i)
        expected_words.push_back(lookup_access(s_cmd_i, s_addr_i));
    end
  end

endmodule

FILE: test/tb_set_assoc_cache_with_victim_buffer.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_with_victim_buffer
// Drives directed and random accesses with random stalls on both channels;
// a checker module predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_with_victim_buffer;
  import sacvb_pkg::*;

  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_addr = '0;
  logic        s_cmd = CMD_READ;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          sink_on = 1'b0;
  logic [19:0] hot_tags [6];

  always #6 clk_i = ~clk_i;

  set_assoc_cache_with_victim_buffer dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_addr), .s_axis_tuser_i(s_cmd),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data)
  );

  sacvb_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_addr_i(s_addr), .s_cmd_i(s_cmd),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // receiver stalls for a random number of cycles, now and then a long one
  always @(negedge clk_i) begin
    int g;
    if (sink_on) begin
      if (stall_left > 0) begin
        m_ready    <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        if ($urandom_range(0, 199) == 0) g = $urandom_range(40, 120);
        else g = gap_len();
        m_ready    <= (g == 0);
        stall_left <= (g > 0) ? g - 1 : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // hold valid across back-to-back words; drop it only for a gap
  task automatic send_access(logic cmd, logic [31:0] addr);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_cmd <= cmd;
    s_addr <= addr;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [31:0] a;
    int pick;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    sink_on = 1'b1;
    // directed: address extremes, fill one set past its ways, victim hits
    send_access(CMD_READ, 32'h0000_0000);
    send_access(CMD_WRITE, 32'hFFFF_FFFF);
    send_access(CMD_WRITE, 32'h0000_0000);
    send_access(CMD_READ, 32'hFFFF_FFC0);
    for (int i = 1; i <= 10; i++)
      send_access(i[0] ? CMD_WRITE : CMD_READ, {i[19:0], 6'd5, 6'h2A});
    send_access(CMD_READ, {20'd1, 6'd5, 6'h00});
    send_access(CMD_WRITE, {20'd2, 6'd5, 6'h3F});
    send_access(CMD_READ, 32'h5555_5555);
    send_access(CMD_WRITE, 32'hAAAA_AAAA);
    // drive one set 255+ times so ages saturate
    for (int i = 0; i < 300; i++) send_access(CMD_READ, {20'd7, 6'd9, 6'd0});
    send_access(CMD_WRITE, {20'd8, 6'd9, 6'd0});
    for (int i = 0; i < 6; i++) hot_tags[i] = 20'($urandom());
    for (int n = 0; n < 1130; n++) begin
      pick = $urandom_range(0, 9);
      a = $urandom();
      // mostly a few sets and tags, so hits, evictions and victim hits recur
      if (pick < 8) begin
        a[11:6] = 6'($urandom_range(0, 3));
        a[31:12] = hot_tags[$urandom_range(0, 5)] ^ 20'($urandom_range(0, 3));
      end
      send_access(1'($urandom_range(0, 1)), a);
    end
    s_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
